// File: rtl/ucbrs_pkg.sv
`timescale 1ns / 1ps
// Package for the UCB/RAVE child scorer: widths, pipeline depths, register codes
// and the request and result payload types. No dependencies.
package ucbrs_pkg;

    // Field widths
    localparam int COUNT_BITS      = 24;
    localparam int SCORE_FRAC_BITS = 16;
    localparam int SCORE_W         = 8 + SCORE_FRAC_BITS;
    localparam int RATIO_W         = SCORE_W + 1;
    localparam int CFG_W           = 16;
    localparam int BB_W            = 2 * CFG_W;

    // Blend weight beta in Q.30, at most one
    localparam int BETA_FRAC = 30;
    localparam int BETA_W    = BETA_FRAC + 1;
    localparam int X_FRAC    = 22;
    localparam int BETA_NUM  = 52;

    // Natural log: integer part of log2, fraction by repeated squaring
    localparam int LOG_FRAC  = 20;
    localparam int LOG_INT_W = 5;
    localparam int L2_W      = LOG_INT_W + LOG_FRAC;
    localparam int MANT_W    = 32;
    localparam int LN_W      = L2_W;
    localparam logic [MANT_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam int V_SHIFT   = 28;
    localparam int T2_SHIFT  = 36 - SCORE_FRAC_BITS;

    // Pipelined restoring divider
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 57;
    localparam int DIV_REM_W = DIV_DEN_W + 1;
    localparam int DIV_STEP  = 2;
    localparam int DIV_LAT   = DIV_NUM_W / DIV_STEP;

    // Pipelined square root, two result bits per stage
    localparam int SQRT_RAD_W  = DIV_NUM_W;
    localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;
    localparam int SQRT_REM_W  = SQRT_ROOT_W + 3;
    localparam int SQRT_STEP   = 2;
    localparam int SQRT_LAT    = SQRT_ROOT_W / SQRT_STEP;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_EXPL_BIAS = 1'b0;
    localparam logic REG_RAVE_BIAS = 1'b1;
    localparam logic [CFG_W-1:0] EXPL_BIAS_RST = 16'd4096;
    localparam logic [CFG_W-1:0] RAVE_BIAS_RST = 16'd410;

    typedef struct packed {
        logic [COUNT_BITS-1:0] child_wins;
        logic [COUNT_BITS-1:0] child_visits;
        logic [COUNT_BITS-1:0] rave_wins;
        logic [COUNT_BITS-1:0] rave_visits;
        logic [COUNT_BITS-1:0] parent_visits;
    } t_req;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               count_error;
    } t_res;

endpackage

// File: rtl/ucbrs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, two quotient bits per stage, DIV_LAT stages.
// Depends on ucbrs_pkg for its widths. Division by zero gives all ones.
module ucbrs_div
    import ucbrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic [DIV_REM_W-1:0] r_rem [DIV_LAT];
    logic [DIV_NUM_W-1:0] r_nq  [DIV_LAT];
    logic [DIV_DEN_W-1:0] r_den [DIV_LAT];
    logic [DIV_REM_W-1:0] n_rem [DIV_LAT];
    logic [DIV_NUM_W-1:0] n_nq  [DIV_LAT];

    for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
        logic [DIV_REM_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] nq_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_NUM_W-1:0] nq;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign nq_in  = r_nq[s-1];
            assign den_in = r_den[s-1];
        end

        // Shift in the next numerator bit, subtract when it fits
        always_comb begin
            rem = rem_in;
            nq  = nq_in;
            for (int b = 0; b < DIV_STEP; b++) begin
                rem = {rem[DIV_REM_W-2:0], nq[DIV_NUM_W-1]};
                nq  = {nq[DIV_NUM_W-2:0], 1'b0};
                if (rem >= {1'b0, den_in}) begin
                    rem   = rem - {1'b0, den_in};
                    nq[0] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_nq[s]  = nq;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem[s];
            r_nq[s]  <= n_nq[s];
            r_den[s] <= den_in;
        end
    end

    assign o_quo = r_nq[DIV_LAT-1];

endmodule

// File: rtl/ucbrs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root, two root bits per stage, SQRT_LAT stages.
// Depends on ucbrs_pkg for its widths.
module ucbrs_sqrt
    import ucbrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic [SQRT_RAD_W-1:0]  i_rad,
    output logic [SQRT_ROOT_W-1:0] o_root
);

    logic [SQRT_REM_W-1:0]  r_rem  [SQRT_LAT];
    logic [SQRT_RAD_W-1:0]  r_rad  [SQRT_LAT];
    logic [SQRT_ROOT_W-1:0] r_root [SQRT_LAT];
    logic [SQRT_REM_W-1:0]  n_rem  [SQRT_LAT];
    logic [SQRT_RAD_W-1:0]  n_rad  [SQRT_LAT];
    logic [SQRT_ROOT_W-1:0] n_root [SQRT_LAT];

    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
        logic [SQRT_REM_W-1:0]  rem_in;
        logic [SQRT_RAD_W-1:0]  rad_in;
        logic [SQRT_ROOT_W-1:0] root_in;
        logic [SQRT_REM_W-1:0]  rem;
        logic [SQRT_RAD_W-1:0]  rad;
        logic [SQRT_ROOT_W-1:0] root;
        logic [SQRT_REM_W-1:0]  trial;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign rad_in  = r_rad[s-1];
            assign root_in = r_root[s-1];
        end

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            rem   = rem_in;
            rad   = rad_in;
            root  = root_in;
            trial = '0;
            for (int b = 0; b < SQRT_STEP; b++) begin
                rem   = {rem[SQRT_REM_W-3:0], rad[SQRT_RAD_W-1 -: 2]};
                rad   = {rad[SQRT_RAD_W-3:0], 2'b00};
                trial = {1'b0, root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[SQRT_ROOT_W-2:0], 1'b1};
                end else begin
                    root = {root[SQRT_ROOT_W-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_rad[s]  = rad;
            n_root[s] = root;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem[s];
            r_rad[s]  <= n_rad[s];
            r_root[s] <= n_root[s];
        end
    end

    assign o_root = r_root[SQRT_LAT-1];

endmodule

// File: rtl/ucb_rave_score.sv
`timescale 1ns / 1ps
// UCB score with RAVE blending for one search-tree child; one request per cycle.
// The result strobe follows an accepted request through the log squaring chain,
// a 28-stage divider, and the 14-stage square root.
// Throughput: one request every cycle; busy stays low and the receiver cannot stall.
// Reset clears the valid pipeline and loads the bias registers with their defaults.
// Depends on ucbrs_pkg, ucbrs_div and ucbrs_sqrt.
module ucb_rave_score
    import ucbrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_strobe,
    output t_res              o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Stage numbers, counted from the request register
    localparam int STG_X    = DIV_LAT + 1;
    localparam int STG_BETA = STG_X + DIV_LAT;
    localparam int STG_T13  = STG_BETA + 1;
    localparam int LOG_SQ_STG = LOG_FRAC;
    localparam int STG_LN   = LOG_SQ_STG + 2;
    localparam int STG_V    = STG_LN + DIV_LAT;
    localparam int STG_T2   = STG_V + SQRT_LAT + 1;
    localparam int D_N      = DIV_LAT - 1;
    localparam int D_R      = STG_BETA - STG_X + 1;
    localparam int D_T      = STG_T2 - STG_T13 + 1;
    localparam int PROD_W   = RATIO_W + BETA_W;
    localparam int SUM_W    = SCORE_W + 3;
    localparam logic [SCORE_W-1:0]   FULL  = '1;
    localparam logic [RATIO_W-1:0]   CAP   = RATIO_W'(1) << SCORE_W;
    localparam logic [BETA_W-1:0]    ONE_B = BETA_W'(1) << BETA_FRAC;

    // Configuration registers
    logic [CFG_W-1:0] r_expl_bias;
    logic [CFG_W-1:0] r_rave_bias;
    logic [BB_W-1:0]  r_bb;

    // Request stage
    t_req r_in;
    logic r_vld  [STG_T2 + 1];
    logic r_err  [STG_T2];
    logic r_none [STG_BETA];
    logic [COUNT_BITS-1:0] r_nd [D_N];

    // RAVE blend path
    logic [DIV_NUM_W-1:0] quo_a;
    logic [DIV_NUM_W-1:0] quo_r1;
    logic [DIV_NUM_W-1:0] quo_r3;
    logic [DIV_NUM_W-1:0] quo_b;
    logic [BB_W+COUNT_BITS-1:0] prod_c;
    logic [DIV_NUM_W-1:0] r_c;
    logic [DIV_DEN_W-1:0] r_x;
    logic [RATIO_W-1:0]   r_r1c [D_R];
    logic [RATIO_W-1:0]   r_r3c [D_R];
    logic [BETA_W-1:0]    beta_m;
    logic [PROD_W-1:0]    prod_t1;
    logic [PROD_W-1:0]    prod_t3;
    logic [RATIO_W-1:0]   r_t1 [D_T];
    logic [RATIO_W-1:0]   r_t3 [D_T];

    // Confidence path
    logic [LOG_INT_W-1:0] msb_idx;
    logic [MANT_W-1:0]    mant0;
    logic [LOG_INT_W-1:0] r_p  [LOG_SQ_STG + 1];
    logic [MANT_W-1:0]    r_m  [LOG_SQ_STG + 1];
    logic [LOG_FRAC-1:0]  r_f  [LOG_SQ_STG + 1];
    logic [L2_W+MANT_W-1:0] prod_ln;
    logic [LN_W-1:0]      r_ln;
    logic [DIV_NUM_W-1:0] quo_v;
    logic [SQRT_ROOT_W-1:0] root;
    logic [CFG_W+SQRT_ROOT_W-1:0] prod_t2;
    logic [SCORE_W-1:0]   r_t2;

    // Output
    logic [SUM_W-1:0] sum;
    t_res             r_res;
    logic             r_strobe;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Write configuration registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expl_bias <= EXPL_BIAS_RST;
            r_rave_bias <= RAVE_BIAS_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_EXPL_BIAS: r_expl_bias <= pwdata[CFG_W-1:0];
                REG_RAVE_BIAS: r_rave_bias <= pwdata[CFG_W-1:0];
                default:       r_rave_bias <= r_rave_bias;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (paddr[2])
            REG_EXPL_BIAS: prdata = {{(DATA_W-CFG_W){1'b0}}, r_expl_bias};
            REG_RAVE_BIAS: prdata = {{(DATA_W-CFG_W){1'b0}}, r_rave_bias};
            default:       prdata = '0;
        endcase
    end

    // Square RAVE bias; user must change it only while idle; not enforced
    always_ff @(posedge i_clk) begin
        r_bb <= r_rave_bias * r_rave_bias;
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        r_in <= i_req;
    end

    // Advance valid, error and no-RAVE flags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STG_T2 + 1; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < STG_T2 + 1; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_err[0]  <= (r_in.child_visits == '0) || (r_in.parent_visits == '0);
        r_none[0] <= (r_in.rave_visits == '0);
        r_nd[0]   <= r_in.child_visits;
        for (int k = 1; k < STG_T2; k++) r_err[k] <= r_err[k-1];
        for (int k = 1; k < STG_BETA; k++) r_none[k] <= r_none[k-1];
        for (int k = 1; k < D_N; k++) r_nd[k] <= r_nd[k-1];
    end

    // Dividers on the request stage: n/nr for beta, and both win ratios
    ucbrs_div u_div_a (
        .i_clk (i_clk),
        .i_num ({{(DIV_NUM_W-COUNT_BITS-X_FRAC){1'b0}}, r_in.child_visits, {X_FRAC{1'b0}}}),
        .i_den ({{(DIV_DEN_W-COUNT_BITS){1'b0}}, r_in.rave_visits}),
        .o_quo (quo_a)
    );

    ucbrs_div u_div_r1 (
        .i_clk (i_clk),
        .i_num ({{(DIV_NUM_W-COUNT_BITS-SCORE_FRAC_BITS){1'b0}}, r_in.child_wins,
                 {SCORE_FRAC_BITS{1'b0}}}),
        .i_den ({{(DIV_DEN_W-COUNT_BITS){1'b0}}, r_in.child_visits}),
        .o_quo (quo_r1)
    );

    ucbrs_div u_div_r3 (
        .i_clk (i_clk),
        .i_num ({{(DIV_NUM_W-COUNT_BITS-SCORE_FRAC_BITS){1'b0}}, r_in.rave_wins,
                 {SCORE_FRAC_BITS{1'b0}}}),
        .i_den ({{(DIV_DEN_W-COUNT_BITS){1'b0}}, r_in.rave_visits}),
        .o_quo (quo_r3)
    );

    // Form b^2*n in Q.22 (4*b^2 with b in Q.12), then the beta denominator
    assign prod_c = r_bb * r_nd[D_N-1];

    always_ff @(posedge i_clk) begin
        r_c <= prod_c;
        r_x <= {1'b0, quo_a} + (DIV_DEN_W'(1) << X_FRAC) + {1'b0, r_c};
    end

    // Cap both win ratios and hold them until beta is ready
    always_ff @(posedge i_clk) begin
        r_r1c[0] <= (quo_r1 > DIV_NUM_W'(CAP)) ? CAP : quo_r1[RATIO_W-1:0];
        r_r3c[0] <= (quo_r3 > DIV_NUM_W'(CAP)) ? CAP : quo_r3[RATIO_W-1:0];
        for (int k = 1; k < D_R; k++) begin
            r_r1c[k] <= r_r1c[k-1];
            r_r3c[k] <= r_r3c[k-1];
        end
    end

    ucbrs_div u_div_b (
        .i_clk (i_clk),
        .i_num (DIV_NUM_W'(1) << BETA_NUM),
        .i_den (r_x),
        .o_quo (quo_b)
    );

    // Blend the exploitation and RAVE terms
    assign beta_m  = r_none[STG_BETA-1] ? '0 : quo_b[BETA_W-1:0];
    assign prod_t1 = r_r1c[D_R-1] * (ONE_B - beta_m);
    assign prod_t3 = r_r3c[D_R-1] * beta_m;

    always_ff @(posedge i_clk) begin
        r_t1[0] <= prod_t1[BETA_FRAC +: RATIO_W];
        r_t3[0] <= prod_t3[BETA_FRAC +: RATIO_W];
        for (int k = 1; k < D_T; k++) begin
            r_t1[k] <= r_t1[k-1];
            r_t3[k] <= r_t3[k-1];
        end
    end

    // Find the leading one of the parent count and normalize to Q1.31
    always_comb begin
        msb_idx = '0;
        for (int k = 0; k < COUNT_BITS; k++) begin
            if (r_in.parent_visits[k]) msb_idx = LOG_INT_W'(k);
        end
        mant0 = {{(MANT_W-COUNT_BITS){1'b0}}, r_in.parent_visits}
                << (LOG_INT_W'(MANT_W-1) - msb_idx);
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= msb_idx;
        r_m[0] <= mant0;
        r_f[0] <= '0;
    end

    // Square the mantissa once per stage, one log2 fraction bit each
    for (genvar s = 1; s <= LOG_SQ_STG; s++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sq_top;

        assign sq     = r_m[s-1] * r_m[s-1];
        assign sq_top = sq[2*MANT_W-1 -: MANT_W+1];

        always_ff @(posedge i_clk) begin
            r_p[s] <= r_p[s-1];
            r_m[s] <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            r_f[s] <= {r_f[s-1][LOG_FRAC-2:0], sq_top[MANT_W]};
        end
    end

    // Scale log2 by ln 2
    assign prod_ln = {r_p[LOG_SQ_STG], r_f[LOG_SQ_STG]} * LN2_Q32;

    always_ff @(posedge i_clk) begin
        r_ln <= prod_ln[MANT_W +: LN_W];
    end

    ucbrs_div u_div_v (
        .i_clk (i_clk),
        .i_num ({{(DIV_NUM_W-LN_W-V_SHIFT){1'b0}}, r_ln, {V_SHIFT{1'b0}}}),
        .i_den ({{(DIV_DEN_W-COUNT_BITS){1'b0}}, r_nd[STG_LN-1]}),
        .o_quo (quo_v)
    );

    ucbrs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (quo_v),
        .o_root (root)
    );

    // Weight the confidence term by the exploration bias
    assign prod_t2 = r_expl_bias * root;

    always_ff @(posedge i_clk) begin
        r_t2 <= prod_t2[T2_SHIFT +: SCORE_W];
    end

    // Sum, saturate, and drop the score on a zero count
    assign sum = SUM_W'(r_t1[D_T-1]) + SUM_W'(r_t2) + SUM_W'(r_t3[D_T-1]);

    always_ff @(posedge i_clk) begin
        if (r_err[STG_T2-1]) begin
            r_res.score <= '0;
        end else if (sum > SUM_W'(FULL)) begin
            r_res.score <= FULL;
        end else begin
            r_res.score <= sum[SCORE_W-1:0];
        end
        r_res.count_error <= r_err[STG_T2-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[STG_T2];
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
